@@ rtl/core/cpa_pkg.sv @@
// shared types, codes and helpers for the context priority arbiter
// no dependencies
package cpa_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_TIME_WIDTH  = 32;
  localparam int SEQ_W           = 32;
  localparam int IDX_W           = 8;

  localparam logic [3:0] KIND_PUBLISH        = 4'd0;
  localparam logic [3:0] KIND_DISMISS        = 4'd1;
  localparam logic [3:0] KIND_DISMISS_INST   = 4'd2;
  localparam logic [3:0] KIND_EXPIRE         = 4'd3;
  localparam logic [3:0] KIND_ACTIVATE       = 4'd4;
  localparam logic [3:0] KIND_DISMISS_ACTIVE = 4'd5;
  localparam logic [3:0] KIND_AVAILABLE      = 4'd6;
  localparam logic [3:0] KIND_FIND           = 4'd7;
  localparam logic [3:0] KIND_QUERY_ACTIVE   = 4'd8;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic CFG_IDX_COMPACT  = 1'b0;
  localparam logic CFG_IDX_EXPANDED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic       has_exp;
    logic       expanded;
    logic       compact;
    logic [7:0] prio;
    logic [7:0] ctx;
    logic [7:0] inst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [SEQ_W-1:0] seq;
    entry_t           ent;
  } cand_t;

  typedef struct packed {
    logic [7:0] inst;
    logic [7:0] ctx;
    logic [7:0] fb_inst;
    logic       slot;
    logic       purge_en;
    logic       dinst_en;
    logic [7:0] act_inst;
    logic [7:0] act_ctx;
  } scan_req_t;

  typedef struct packed {
    cand_t match;
    cand_t free;
    cand_t act;
    cand_t best0;
    cand_t best1;
    cand_t best2;
  } scan_res_t;

  // higher priority wins, then newer sequence; equal keeps the earlier index
  function automatic logic cand_better(cand_t c, cand_t b);
    logic r;
    r = !b.hit || (c.ent.prio > b.ent.prio) ||
        ((c.ent.prio == b.ent.prio) && (c.seq > b.seq));
    return r;
  endfunction

endpackage

@@ rtl/core/cpa_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module cpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/cpa_scan.sv @@
// per-entry evaluation during a table sweep: purge test, key lookups,
// free slot and best-candidate tracking; uses cpa_pkg
module cpa_scan #(
  parameter int TIME_WIDTH = cpa_pkg::DEF_TIME_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      rd_valid,
  input  logic [cpa_pkg::IDX_W-1:0] rd_idx,
  input  logic                      entry_valid,
  input  cpa_pkg::entry_t           rd_ent,
  input  logic [TIME_WIDTH-1:0]     rd_expiry,
  input  logic [cpa_pkg::SEQ_W-1:0] rd_seq,
  input  cpa_pkg::scan_req_t        req,
  input  logic [TIME_WIDTH-1:0]     now_t,
  output logic                      kill,
  output cpa_pkg::scan_res_t        res
);
  import cpa_pkg::*;

  logic      expired;
  logic      live;
  logic      slot_ok;
  cand_t     cur;
  scan_res_t res_next;

  always_comb begin
    expired = req.purge_en && rd_ent.has_exp && (rd_expiry <= now_t);
    live    = entry_valid && !expired;
    slot_ok = req.slot ? rd_ent.expanded : rd_ent.compact;
    kill    = rd_valid && entry_valid &&
              (expired || (req.dinst_en && rd_ent.inst == req.inst));
    cur.hit = 1'b1;
    cur.idx = rd_idx;
    cur.seq = rd_seq;
    cur.ent = rd_ent;

    res_next = res;
    if (rd_valid) begin
      if (live && rd_ent.inst == req.inst && rd_ent.ctx == req.ctx && !res.match.hit) begin
        res_next.match = cur;
      end
      if (!live && !res.free.hit) begin
        res_next.free = cur;
      end
      if (live && rd_ent.inst == req.act_inst && rd_ent.ctx == req.act_ctx &&
          !res.act.hit) begin
        res_next.act = cur;
      end
      if (live && rd_ent.inst == req.inst && cand_better(cur, res.best0)) begin
        res_next.best0 = cur;
      end
      if (live && slot_ok && rd_ent.inst == req.fb_inst && cand_better(cur, res.best1)) begin
        res_next.best1 = cur;
      end
      if (live && slot_ok && rd_ent.inst != req.fb_inst && cand_better(cur, res.best2)) begin
        res_next.best2 = cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      res <= '0;
    end else begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/core/context_priority_arbiter_core.sv @@
// context priority arbiter top: request registers, sweep sequencer, valid bits,
// activation state and result register; uses cpa_pkg, cpa_ram, cpa_scan
// an item is handled in order: a sweep of the entry ram, one entry per cycle through
// its one read port, then a drain state, then a commit (write-back) state; a new
// item is accepted only in the idle state after the previous commit; a result held
// by out_ready low stalls the write-back
// reset (synchronous, rst high): all entries invalid, activation cleared,
// sequence counter and default instances zero; no clearing pass is needed
module context_priority_arbiter_core #(
  parameter int TABLE_DEPTH = cpa_pkg::DEF_TABLE_DEPTH,
  parameter int TIME_WIDTH  = cpa_pkg::DEF_TIME_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  kind,
  input  logic [7:0]  inst_id,
  input  logic [7:0]  ctx_id,
  input  logic [7:0]  priority_req,
  input  logic        has_compact,
  input  logic        has_expanded,
  input  logic        has_time_limit,
  input  logic [31:0] time_limit,
  input  logic [31:0] now,
  input  logic        slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  found_instance,
  output logic [7:0]  found_context,
  output logic [7:0]  found_priority,
  output logic        found_compact,
  output logic        found_expanded
);
  import cpa_pkg::*;

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WORD_W = ENTRY_W + TIME_WIDTH + SEQ_W;

  state_t state;
  state_t state_next;

  logic [7:0] cmp_fallback;
  logic [7:0] exp_fallback;

  logic [3:0]            kind_r;
  logic [7:0]            inst_r;
  logic [7:0]            ctx_r;
  logic [7:0]            prio_r;
  logic                  hc_r;
  logic                  he_r;
  logic                  ht_r;
  logic [TIME_WIDTH-1:0] tl_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic                  slot_r;

  logic [SEQ_W-1:0]      seq_counter;
  logic                  act_valid;
  logic [15:0]           act_key;
  logic                  act_hd;
  logic [TIME_WIDTH-1:0] act_dl;

  logic [TABLE_DEPTH-1:0] valid;

  logic [AW:0]   scan_cnt;
  logic          issue;
  logic          scan_last;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;

  logic              accept;
  logic              fire;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_we;
  logic              pub_we;
  logic [AW-1:0]     widx;

  scan_req_t sreq;
  scan_res_t sr;
  logic      kill;
  entry_t    rd_ent;
  entry_t    new_ent;

  logic   purge;
  logic   tl_expired;
  logic   act_alive;
  logic   act_contrib;
  cand_t  sel;
  logic   nx_act_valid;
  logic   act_load;
  logic   v_set;
  logic   v_clr;
  logic [AW-1:0] v_idx;
  logic [1:0] o_status;
  entry_t o_ent;

  // fsm: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_COMMIT;
      ST_COMMIT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // fsm: outputs
  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    fire      = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   issue = 1'b1;
      ST_DRAIN:  ;
      ST_COMMIT: fire = !out_valid || out_ready;
      default:   ;
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign scan_last = scan_cnt == (AW+1)'(TABLE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (accept) begin
        scan_cnt <= '0;
      end else if (issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_fallback <= '0;
      exp_fallback <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_COMPACT) cmp_fallback <= cfg_data;
      if (cfg_index == CFG_IDX_EXPANDED) exp_fallback <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      inst_r <= inst_id;
      ctx_r  <= ctx_id;
      prio_r <= priority_req;
      hc_r   <= has_compact;
      he_r   <= has_expanded;
      ht_r   <= has_time_limit;
      tl_r   <= TIME_WIDTH'(time_limit);
      now_r  <= TIME_WIDTH'(now);
      // dismiss active always looks at the compact slot
      slot_r <= (kind == KIND_DISMISS_ACTIVE) ? 1'b0 : slot;
    end
  end

  always_comb begin
    purge = kind_r inside {KIND_EXPIRE, KIND_ACTIVATE, KIND_DISMISS_ACTIVE,
                           KIND_AVAILABLE, KIND_FIND, KIND_QUERY_ACTIVE};
    sreq.inst     = inst_r;
    sreq.ctx      = ctx_r;
    sreq.fb_inst  = slot_r ? exp_fallback : cmp_fallback;
    sreq.slot     = slot_r;
    sreq.purge_en = purge;
    sreq.dinst_en = kind_r == KIND_DISMISS_INST;
    sreq.act_inst = act_key[7:0];
    sreq.act_ctx  = act_key[15:8];
  end

  assign rd_ent = entry_t'(ram_rdata[ENTRY_W-1:0]);

  cpa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(widx),
    .wdata(ram_wdata),
    .raddr(scan_cnt[AW-1:0]),
    .rdata(ram_rdata)
  );

  cpa_scan #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .rd_valid   (rd_valid),
    .rd_idx     (IDX_W'(rd_idx)),
    .entry_valid(valid[rd_idx]),
    .rd_ent     (rd_ent),
    .rd_expiry  (ram_rdata[ENTRY_W +: TIME_WIDTH]),
    .rd_seq     (ram_rdata[ENTRY_W+TIME_WIDTH +: SEQ_W]),
    .req        (sreq),
    .now_t      (now_r),
    .kill       (kill),
    .res        (sr)
  );

  // commit decision once the sweep is complete
  always_comb begin
    tl_expired  = ht_r && (tl_r <= now_r);
    act_alive   = purge ? (act_valid && !(act_hd && act_dl <= now_r) && sr.act.hit)
                        : act_valid;
    act_contrib = slot_r ? sr.act.ent.expanded : sr.act.ent.compact;
    if (act_alive && act_contrib) begin
      sel = sr.act;
    end else if (sr.best2.hit) begin
      sel = sr.best2;
    end else begin
      sel = sr.best1;
    end

    nx_act_valid = act_valid;
    act_load     = 1'b0;
    pub_we       = 1'b0;
    v_set        = 1'b0;
    v_clr        = 1'b0;
    v_idx        = sr.match.idx[AW-1:0];
    widx         = sr.match.idx[AW-1:0];
    o_status     = STATUS_NONE;
    o_ent        = '0;

    new_ent.has_exp  = ht_r;
    new_ent.expanded = he_r;
    new_ent.compact  = hc_r;
    new_ent.prio     = prio_r;
    new_ent.ctx      = ctx_r;
    new_ent.inst     = inst_r;

    case (kind_r)
      KIND_PUBLISH: begin
        o_status = STATUS_OK;
        if (tl_expired) begin
          v_clr = sr.match.hit;
          if (act_key == {ctx_r, inst_r}) nx_act_valid = 1'b0;
        end else if (sr.match.hit || sr.free.hit) begin
          pub_we = 1'b1;
          v_set  = 1'b1;
          if (!sr.match.hit) begin
            widx  = sr.free.idx[AW-1:0];
            v_idx = sr.free.idx[AW-1:0];
          end
        end else begin
          o_status = STATUS_FULL;
        end
      end
      KIND_DISMISS: begin
        o_status = STATUS_OK;
        v_clr    = sr.match.hit;
        if (act_key == {ctx_r, inst_r}) nx_act_valid = 1'b0;
      end
      KIND_DISMISS_INST: begin
        o_status = STATUS_OK;
        if (act_key[7:0] == inst_r) nx_act_valid = 1'b0;
      end
      KIND_EXPIRE: begin
        o_status     = STATUS_OK;
        nx_act_valid = act_alive;
      end
      KIND_ACTIVATE: begin
        nx_act_valid = act_alive;
        if (sr.best0.hit) begin
          nx_act_valid = 1'b1;
          act_load     = 1'b1;
          o_status     = STATUS_OK;
          o_ent        = sr.best0.ent;
        end
      end
      KIND_DISMISS_ACTIVE: begin
        nx_act_valid = act_alive;
        if (sel.hit && sel.ent.ctx == ctx_r) begin
          o_status = STATUS_OK;
          o_ent    = sel.ent;
          v_clr    = 1'b1;
          v_idx    = sel.idx[AW-1:0];
          if (act_key == {sel.ent.ctx, sel.ent.inst}) nx_act_valid = 1'b0;
        end
      end
      KIND_AVAILABLE: begin
        nx_act_valid = act_alive;
        if (sr.best0.hit) begin
          o_status = STATUS_OK;
          o_ent    = sr.best0.ent;
        end
      end
      KIND_FIND: begin
        nx_act_valid = act_alive;
        if (sr.match.hit) begin
          o_status = STATUS_OK;
          o_ent    = sr.match.ent;
        end
      end
      KIND_QUERY_ACTIVE: begin
        nx_act_valid = act_alive;
        if (sel.hit) begin
          o_status = STATUS_OK;
          o_ent    = sel.ent;
        end
      end
      default: o_status = STATUS_NONE;
    endcase
  end

  assign ram_we    = fire && pub_we;
  assign ram_wdata = {seq_counter + 1'b1, tl_r, new_ent};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (kill) valid[rd_idx] <= 1'b0;
      if (fire && v_clr) valid[v_idx] <= 1'b0;
      if (fire && v_set) valid[v_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_counter <= '0;
      act_valid   <= 1'b0;
      act_key     <= '0;
      act_hd      <= 1'b0;
      act_dl      <= '0;
    end else if (fire) begin
      act_valid <= nx_act_valid;
      if (pub_we) seq_counter <= seq_counter + 1'b1;
      if (act_load) begin
        act_key <= {sr.best0.ent.ctx, sr.best0.ent.inst};
        act_hd  <= ht_r;
        act_dl  <= ht_r ? tl_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status         <= o_status;
      found_instance <= o_ent.inst;
      found_context  <= o_ent.ctx;
      found_priority <= o_ent.prio;
      found_compact  <= o_ent.compact;
      found_expanded <= o_ent.expanded;
    end
  end

  a_ram_we_commit: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_COMMIT)
    else $error("entry ram written outside commit");

  a_seq_on_publish: assert property (@(posedge clk) disable iff (rst)
    seq_counter != $past(seq_counter) |-> $past(ram_we))
    else $error("sequence counter moved without a stored publish");

  a_read_in_sweep: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> state == ST_SCAN || state == ST_DRAIN)
    else $error("read data returned outside the sweep");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |->
      found_instance == 8'd0 && found_context == 8'd0 && found_priority == 8'd0)
    else $error("fields not cleared on a failed item");

endmodule

@@ verif/context_priority_arbiter_core_test.sv @@
// testbench for context_priority_arbiter_core: random and directed context requests,
// results checked against a behavioral table model kept in this file
// depends on cpa_pkg and the rtl of the arbiter core
module context_priority_arbiter_core_test;
  import cpa_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  inst;
    logic [7:0]  ctx;
    logic [7:0]  prio;
    logic        hc;
    logic        he;
    logic        ht;
    logic [31:0] tl;
    logic [31:0] now;
    logic        slot;
  } req_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] inst;
    logic [7:0] ctx;
    logic [7:0] prio;
    logic       comp;
    logic       expd;
  } answer_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0, cfg_index = 0;
  logic [7:0] cfg_data = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [3:0] kind = 0;
  logic [7:0] inst_id = 0, ctx_id = 0, priority_req = 0;
  logic has_compact = 0, has_expanded = 0, has_time_limit = 0, slot = 0;
  logic [31:0] time_limit = 0, now = 0;
  logic [1:0] status;
  logic [7:0] found_instance, found_context, found_priority;
  logic found_compact, found_expanded;

  context_priority_arbiter_core uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // model state
  logic        t_valid [DEPTH];
  logic [7:0]  t_inst [DEPTH], t_ctx [DEPTH], t_prio [DEPTH];
  logic        t_comp [DEPTH], t_expd [DEPTH], t_hasexp [DEPTH];
  logic [31:0] t_exp [DEPTH], t_seq [DEPTH];
  logic [31:0] seq_count;
  logic        act_valid, act_hasdl;
  logic [7:0]  act_inst, act_ctx;
  logic [31:0] act_dl;
  logic [7:0]  def_inst [2];

  req_t    pending [$];
  answer_t expected [$];
  int      errors = 0;
  int      accepted = 0;
  logic    stim_done = 0;

  function automatic int find_key(logic [7:0] i, logic [7:0] c);
    for (int k = 0; k < DEPTH; k++)
      if (t_valid[k] && t_inst[k] == i && t_ctx[k] == c) return k;
    return -1;
  endfunction

  function automatic void drop_key(logic [7:0] i, logic [7:0] c);
    int k;
    k = find_key(i, c);
    if (k >= 0) t_valid[k] = 0;
    if (act_valid && act_inst == i && act_ctx == c) act_valid = 0;
  endfunction

  function automatic void purge_expired(logic [31:0] tnow);
    for (int k = 0; k < DEPTH; k++)
      if (t_valid[k] && t_hasexp[k] && t_exp[k] <= tnow) t_valid[k] = 0;
    if (act_valid && ((act_hasdl && act_dl <= tnow) || find_key(act_inst, act_ctx) < 0))
      act_valid = 0;
  endfunction

  function automatic logic flag_of(int k, logic s);
    return s ? t_expd[k] : t_comp[k];
  endfunction

  // mode 0: same instance; 1: same instance and in slot; 2: other instance and in slot
  function automatic int best_entry(logic [7:0] i, int mode, logic s);
    int b;
    b = -1;
    for (int k = 0; k < DEPTH; k++) begin
      if (!t_valid[k]) continue;
      if (mode == 2 ? t_inst[k] == i : t_inst[k] != i) continue;
      if (mode != 0 && !flag_of(k, s)) continue;
      if (b < 0 || t_prio[k] > t_prio[b] || (t_prio[k] == t_prio[b] && t_seq[k] > t_seq[b]))
        b = k;
    end
    return b;
  endfunction

  function automatic int slot_winner(logic s, logic [31:0] tnow);
    int k;
    purge_expired(tnow);
    if (act_valid) begin
      k = find_key(act_inst, act_ctx);
      if (k >= 0 && flag_of(k, s)) return k;
    end
    k = best_entry(def_inst[s], 2, s);
    if (k >= 0) return k;
    return best_entry(def_inst[s], 1, s);
  endfunction

  function automatic answer_t make_answer(logic [1:0] st, int k);
    answer_t a;
    a = '{st, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
    if (st == STATUS_OK && k >= 0)
      a = '{st, t_inst[k], t_ctx[k], t_prio[k], t_comp[k], t_expd[k]};
    return a;
  endfunction

  function automatic answer_t arbitrate(req_t r);
    int k;
    answer_t a;
    case (r.kind)
      KIND_PUBLISH: begin
        if (r.ht && r.tl <= r.now) begin
          drop_key(r.inst, r.ctx);
          return make_answer(STATUS_OK, -1);
        end
        k = find_key(r.inst, r.ctx);
        if (k < 0) begin
          for (int j = DEPTH - 1; j >= 0; j--) if (!t_valid[j]) k = j;
          if (k < 0) return make_answer(STATUS_FULL, -1);
        end
        seq_count++;
        t_valid[k] = 1; t_inst[k] = r.inst; t_ctx[k] = r.ctx; t_prio[k] = r.prio;
        t_comp[k] = r.hc; t_expd[k] = r.he; t_hasexp[k] = r.ht;
        t_exp[k] = r.tl; t_seq[k] = seq_count;
        return make_answer(STATUS_OK, -1);
      end
      KIND_DISMISS: begin
        drop_key(r.inst, r.ctx);
        return make_answer(STATUS_OK, -1);
      end
      KIND_DISMISS_INST: begin
        for (int j = 0; j < DEPTH; j++) if (t_valid[j] && t_inst[j] == r.inst) t_valid[j] = 0;
        if (act_valid && act_inst == r.inst) act_valid = 0;
        return make_answer(STATUS_OK, -1);
      end
      KIND_EXPIRE: begin
        purge_expired(r.now);
        return make_answer(STATUS_OK, -1);
      end
      KIND_ACTIVATE: begin
        purge_expired(r.now);
        k = best_entry(r.inst, 0, 0);
        if (k < 0) return make_answer(STATUS_NONE, -1);
        act_valid = 1; act_inst = t_inst[k]; act_ctx = t_ctx[k];
        act_hasdl = r.ht; act_dl = r.ht ? r.tl : 0;
        return make_answer(STATUS_OK, k);
      end
      KIND_DISMISS_ACTIVE: begin
        k = slot_winner(0, r.now);
        if (k < 0 || t_ctx[k] != r.ctx) return make_answer(STATUS_NONE, -1);
        a = make_answer(STATUS_OK, k);
        drop_key(t_inst[k], t_ctx[k]);
        return a;
      end
      KIND_AVAILABLE: begin
        purge_expired(r.now);
        k = best_entry(r.inst, 0, 0);
        return make_answer(k < 0 ? STATUS_NONE : STATUS_OK, k);
      end
      KIND_FIND: begin
        purge_expired(r.now);
        k = find_key(r.inst, r.ctx);
        return make_answer(k < 0 ? STATUS_NONE : STATUS_OK, k);
      end
      KIND_QUERY_ACTIVE: begin
        k = slot_winner(r.slot, r.now);
        return make_answer(k < 0 ? STATUS_NONE : STATUS_OK, k);
      end
      default: return make_answer(STATUS_NONE, -1);
    endcase
  endfunction

  // small key space so that hits, ties and a full table are common
  function automatic req_t rand_req(logic [31:0] base);
    req_t r;
    r.kind = $urandom_range(0, 99) < 35 ? KIND_PUBLISH : 4'($urandom_range(0, 9));
    if (r.kind == 4'd9) r.kind = 4'($urandom_range(9, 15));
    r.inst = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
    r.ctx = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 5));
    r.prio = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
    r.hc = 1'($urandom); r.he = 1'($urandom); r.ht = 1'($urandom);
    r.slot = 1'($urandom);
    r.now = base;
    r.tl = $urandom_range(0, 19) == 0 ? $urandom : base + $urandom_range(0, 60) - 10;
    return r;
  endfunction

  // handshake flags from the monitor, used by the driver at the falling edge
  logic in_ready_seen = 0;
  logic out_taken = 0;

  // driver
  int gap = 0;
  int out_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready_seen) begin
        in_valid <= 0;
        gap = $urandom_range(0, 4);
      end else if (!in_valid) begin
        if (gap > 0) gap--;
        else if (pending.size() > 0) begin
          req_t r;
          r = pending.pop_front();
          kind <= r.kind; inst_id <= r.inst; ctx_id <= r.ctx;
          priority_req <= r.prio; has_compact <= r.hc; has_expanded <= r.he;
          has_time_limit <= r.ht; time_limit <= r.tl; now <= r.now; slot <= r.slot;
          in_valid <= 1;
        end
      end
      // output side waits a drawn number of cycles after each item
      if (out_ready && out_taken) begin
        out_gap = $urandom_range(0, 4);
        if (out_gap > 0) begin
          out_ready <= 0;
          out_gap--;
        end
      end else if (!out_ready) begin
        if (out_gap > 0) out_gap--;
        else out_ready <= 1;
      end
    end
  end

  // accept and monitor at the rising edge
  always @(posedge clk) begin
    in_ready_seen <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst && in_valid && in_ready) begin
      req_t r;
      r = '{kind, inst_id, ctx_id, priority_req, has_compact, has_expanded,
            has_time_limit, time_limit, now, slot};
      expected.push_back(arbitrate(r));
      accepted++;
    end
    if (!rst && out_valid && out_ready) begin
      answer_t e;
      if (expected.size() == 0) begin
        $error("unexpected item: status %0d", status);
        errors++;
      end else begin
        e = expected.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status); errors++;
        end
        if (found_instance !== e.inst) begin
          $error("found_instance: expected %0d actual %0d", e.inst, found_instance); errors++;
        end
        if (found_context !== e.ctx) begin
          $error("found_context: expected %0d actual %0d", e.ctx, found_context); errors++;
        end
        if (found_priority !== e.prio) begin
          $error("found_priority: expected %0d actual %0d", e.prio, found_priority); errors++;
        end
        if (found_compact !== e.comp) begin
          $error("found_compact: expected %0d actual %0d", e.comp, found_compact); errors++;
        end
        if (found_expanded !== e.expd) begin
          $error("found_expanded: expected %0d actual %0d", e.expd, found_expanded); errors++;
        end
      end
    end
  end

  task automatic write_default(logic idx, logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= value;
    @(negedge clk);
    cfg_we <= 0;
    def_inst[idx] = value;
  endtask

  task automatic run_phase(int count, logic [31:0] base);
    int target;
    target = accepted + count;
    for (int n = 0; n < count; n++) begin
      pending.push_back(rand_req(base));
      base += $urandom_range(0, 6);
    end
    wait (accepted == target && expected.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    req_t r;
    int target;
    for (int k = 0; k < DEPTH; k++) t_valid[k] = 0;
    seq_count = 0; act_valid = 0; act_hasdl = 0; act_inst = 0; act_ctx = 0; act_dl = 0;
    def_inst[0] = 0; def_inst[1] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_default(CFG_IDX_COMPACT, 8'd1);
    write_default(CFG_IDX_EXPANDED, 8'd255);

    // directed: fill past full, ties, expiry, activation, most kinds, field extremes
    for (int n = 0; n < 17; n++) begin
      r = '{KIND_PUBLISH, 8'(n % 3), 8'(n), 8'(n == 16 ? 255 : 5), n[0], n[1], 0, 0, 100, 0};
      pending.push_back(r);
    end
    pending.push_back('{KIND_QUERY_ACTIVE, 0, 0, 0, 0, 0, 0, 0, 100, 1});
    pending.push_back('{KIND_ACTIVATE, 2, 0, 0, 0, 0, 1, 120, 100, 0});
    pending.push_back('{KIND_QUERY_ACTIVE, 0, 0, 0, 0, 0, 0, 0, 110, 0});
    pending.push_back('{KIND_DISMISS_ACTIVE, 0, 2, 0, 0, 0, 0, 0, 130, 0});
    pending.push_back('{KIND_PUBLISH, 255, 255, 255, 1, 1, 1, 32'hffffffff, 0, 1});
    pending.push_back('{KIND_PUBLISH, 1, 1, 9, 1, 1, 1, 50, 60, 0});
    pending.push_back('{KIND_DISMISS_INST, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    pending.push_back('{KIND_EXPIRE, 0, 0, 0, 0, 0, 0, 0, 32'hffffffff, 0});
    pending.push_back('{KIND_FIND, 255, 255, 0, 0, 0, 0, 0, 0, 0});
    pending.push_back('{4'hf, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    target = 27;
    wait (accepted == target && expected.size() == 0);
    repeat (40) @(negedge clk);

    run_phase(170, 32'd1000);
    write_default(CFG_IDX_COMPACT, 8'd0);
    write_default(CFG_IDX_EXPANDED, 8'd2);
    run_phase(170, 32'hffff_fe00);
    write_default(CFG_IDX_COMPACT, 8'd255);
    write_default(CFG_IDX_EXPANDED, 8'd0);
    run_phase(170, 32'd50);
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) $display("context_priority_arbiter_core: match");
    else $display("context_priority_arbiter_core: mismatch");
    $finish;
  end

  initial begin
    #400000;
    $display("context_priority_arbiter_core: mismatch");
    $finish;
  end
endmodule
